[hw/rtl/rtsrc_pkg.sv]
package rtsrc_pkg;

	localparam int unsigned TICK_W = 20;
	localparam int unsigned ADDR_W = 24;
	localparam int unsigned CODE_W = 16;
	localparam int unsigned FRAME_BITS = 56;
	localparam int unsigned BIT_IDX_W = 6;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CODE_W-1:0] MIN_ROLLING_CODE = 16'd1;
	localparam logic [7:0] FRAME_KEY = 8'hA0;
	localparam logic [3:0] NIBBLE_MASK = 4'hF;

	localparam logic [2:0] HW_SYNC_FIRST = 3'd2;
	localparam logic [2:0] HW_SYNC_LATER = 3'd7;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_SEND = 2'd1,
		OP_RESTORE = 2'd2,
		OP_NOP = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REMOTE_ADDRESS = 3'd0,
		REG_WAKEUP_TICKS = 3'd1,
		REG_SILENCE_TICKS = 3'd2,
		REG_HW_SYNC_TICKS = 3'd3,
		REG_SW_SYNC_TICKS = 3'd4,
		REG_HALF_BIT_TICKS = 3'd5,
		REG_GAP_TICKS = 3'd6,
		REG_UNUSED = 3'd7
	} reg_idx_t;

	localparam logic [TICK_W-1:0] WAKEUP_RESET = 20'd9415;
	localparam logic [TICK_W-1:0] SILENCE_RESET = 20'd89565;
	localparam logic [TICK_W-1:0] HW_SYNC_RESET = 20'd2416;
	localparam logic [TICK_W-1:0] SW_SYNC_RESET = 20'd4550;
	localparam logic [TICK_W-1:0] HALF_BIT_RESET = 20'd604;
	localparam logic [TICK_W-1:0] GAP_RESET = 20'd30415;

	typedef enum logic [8:0] {
		PH_IDLE = 9'b000000001,
		PH_WAKE = 9'b000000010,
		PH_SILENCE = 9'b000000100,
		PH_HW_HIGH = 9'b000001000,
		PH_HW_LOW = 9'b000010000,
		PH_SW_SYNC = 9'b000100000,
		PH_POST_SYNC = 9'b001000000,
		PH_DATA = 9'b010000000,
		PH_GAP = 9'b100000000
	} phase_t;

	function automatic logic [TICK_W-1:0] seg_len(input logic [TICK_W-1:0] v);
		seg_len = (v == '0) ? TICK_W'(1) : v;
	endfunction

	function automatic logic [FRAME_BITS-1:0] build_frame(
		input logic [3:0] btn,
		input logic [CODE_W-1:0] code,
		input logic [ADDR_W-1:0] addr
	);
		logic [7:0] b [7];
		logic [3:0] ck;
		b[0] = FRAME_KEY;
		ck = FRAME_KEY[7:4] ^ FRAME_KEY[3:0] ^ btn
			^ code[15:12] ^ code[11:8] ^ code[7:4] ^ code[3:0]
			^ addr[23:20] ^ addr[19:16] ^ addr[15:12] ^ addr[11:8]
			^ addr[7:4] ^ addr[3:0];
		b[1] = {btn, ck & NIBBLE_MASK};
		b[2] = code[15:8];
		b[3] = code[7:0];
		b[4] = addr[23:16];
		b[5] = addr[15:8];
		b[6] = addr[7:0];
		for (int i = 1; i < 7; i++) begin
			b[i] = b[i] ^ b[i-1];
		end
		build_frame = {b[0], b[1], b[2], b[3], b[4], b[5], b[6]};
	endfunction

endpackage

[hw/rtl/rts_rolling_code_frame_transmitter.sv]
// an accepted item's result is registered; the output register frees as it is taken
// throughput: one item per cycle, stalled while a full output register waits for out_ready
// a busy tick steps the waveform counters by one; an idle send builds the frame in one pass
// reset (arst_n low, asynchronous): idle, rolling code 0, timing registers to defaults,
// address 0, output register empty; frame bytes are undefined until the first send
module rts_rolling_code_frame_transmitter (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [1:0]                             op,
	input  logic [3:0]                             button,
	input  logic [7:0]                             repeat_count,
	input  logic [rtsrc_pkg::CODE_W-1:0]           stored_code,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic                                   pin_level,
	output logic                                   busy_res,
	output logic                                   accepted,
	output logic [rtsrc_pkg::CODE_W-1:0]           code_value,
	output logic                                   save_code,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [rtsrc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rtsrc_pkg::ADDR_W-1:0]           cfg_data
);
	import rtsrc_pkg::*;

	logic [ADDR_W-1:0] addr_q;
	logic [TICK_W-1:0] wakeup_q, silence_q, hw_sync_q, sw_sync_q, half_bit_q, gap_q;

	phase_t phase_q, phase_d;
	logic [TICK_W-1:0] seg_q, seg_d, seg_dec;
	logic [8:0] frames_q, frames_d;
	logic [2:0] sync_q, sync_d, sync_dec;
	logic [BIT_IDX_W-1:0] bit_q, bit_d, bit_inc;
	logic half_q, half_d;
	logic [CODE_W-1:0] roll_q, roll_d;
	logic [FRAME_BITS-1:0] frame_q, frame_d;
	logic frame_we;

	logic busy, data_bit, level_now, acc, save, pin;
	logic take;

	logic out_valid_q;
	logic pin_q, busy_q, acc_q, save_q;
	logic [CODE_W-1:0] roll_out_q;

	assign cfg_ready = 1'b1;
	assign in_ready = !out_valid_q || out_ready;
	assign take = in_valid && in_ready;

	assign busy = (phase_q != PH_IDLE);
	assign data_bit = (bit_q < BIT_IDX_W'(FRAME_BITS))
		? frame_q[BIT_IDX_W'(FRAME_BITS - 1) - bit_q] : 1'b0;

	always_comb begin
		case (phase_q)
			PH_WAKE, PH_HW_HIGH, PH_SW_SYNC: level_now = 1'b1;
			PH_DATA: level_now = half_q ? data_bit : !data_bit;
			default: level_now = 1'b0;
		endcase
	end

	assign seg_dec = seg_q - TICK_W'(1);
	assign sync_dec = sync_q - 3'd1;
	assign bit_inc = bit_q + BIT_IDX_W'(1);

	always_comb begin
		phase_d = phase_q;
		seg_d = seg_q;
		frames_d = frames_q;
		sync_d = sync_q;
		bit_d = bit_q;
		half_d = half_q;
		roll_d = roll_q;
		frame_d = frame_q;
		frame_we = 1'b0;
		acc = 1'b0;
		save = 1'b0;
		pin = level_now;
		case (op_t'(op))
			OP_TICK: begin
				if (busy) begin
					seg_d = seg_dec;
					if (seg_dec == '0) begin
						case (phase_q)
							PH_WAKE: begin
								phase_d = PH_SILENCE;
								seg_d = seg_len(silence_q);
							end
							PH_SILENCE: begin
								sync_d = HW_SYNC_FIRST;
								phase_d = PH_HW_HIGH;
								seg_d = seg_len(hw_sync_q);
							end
							PH_HW_HIGH: begin
								phase_d = PH_HW_LOW;
								seg_d = seg_len(hw_sync_q);
							end
							PH_HW_LOW: begin
								sync_d = sync_dec;
								if (sync_dec != '0) begin
									phase_d = PH_HW_HIGH;
									seg_d = seg_len(hw_sync_q);
								end else begin
									phase_d = PH_SW_SYNC;
									seg_d = seg_len(sw_sync_q);
								end
							end
							PH_SW_SYNC: begin
								phase_d = PH_POST_SYNC;
								seg_d = seg_len(half_bit_q);
							end
							PH_POST_SYNC: begin
								bit_d = '0;
								half_d = 1'b0;
								phase_d = PH_DATA;
								seg_d = seg_len(half_bit_q);
							end
							PH_DATA: begin
								if (!half_q) begin
									half_d = 1'b1;
									seg_d = seg_len(half_bit_q);
								end else begin
									half_d = 1'b0;
									bit_d = bit_inc;
									if (bit_inc >= BIT_IDX_W'(FRAME_BITS)) begin
										phase_d = PH_GAP;
										seg_d = seg_len(gap_q);
									end else begin
										seg_d = seg_len(half_bit_q);
									end
								end
							end
							PH_GAP: begin
								if (frames_q != '0) begin
									frames_d = frames_q - 9'd1;
									sync_d = HW_SYNC_LATER;
									phase_d = PH_HW_HIGH;
									seg_d = seg_len(hw_sync_q);
								end else begin
									phase_d = PH_IDLE;
									seg_d = '0;
								end
							end
							default: begin
								phase_d = PH_IDLE;
								seg_d = '0;
							end
						endcase
					end
				end
			end
			OP_SEND: begin
				if (!busy) begin
					frame_d = build_frame(button, roll_q, addr_q);
					frame_we = 1'b1;
					roll_d = roll_q + CODE_W'(1);
					frames_d = {1'b0, repeat_count};
					sync_d = '0;
					bit_d = '0;
					half_d = 1'b0;
					phase_d = PH_WAKE;
					seg_d = seg_len(wakeup_q);
					acc = 1'b1;
					save = 1'b1;
					pin = 1'b1;
				end
			end
			OP_RESTORE: begin
				if (!busy) begin
					if (stored_code < MIN_ROLLING_CODE) begin
						roll_d = MIN_ROLLING_CODE;
						save = 1'b1;
					end else begin
						roll_d = stored_code;
					end
					acc = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			wakeup_q <= WAKEUP_RESET;
			silence_q <= SILENCE_RESET;
			hw_sync_q <= HW_SYNC_RESET;
			sw_sync_q <= SW_SYNC_RESET;
			half_bit_q <= HALF_BIT_RESET;
			gap_q <= GAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_REMOTE_ADDRESS: addr_q <= cfg_data;
				REG_WAKEUP_TICKS: wakeup_q <= cfg_data[TICK_W-1:0];
				REG_SILENCE_TICKS: silence_q <= cfg_data[TICK_W-1:0];
				REG_HW_SYNC_TICKS: hw_sync_q <= cfg_data[TICK_W-1:0];
				REG_SW_SYNC_TICKS: sw_sync_q <= cfg_data[TICK_W-1:0];
				REG_HALF_BIT_TICKS: half_bit_q <= cfg_data[TICK_W-1:0];
				REG_GAP_TICKS: gap_q <= cfg_data[TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			seg_q <= '0;
			frames_q <= '0;
			sync_q <= '0;
			bit_q <= '0;
			half_q <= 1'b0;
			roll_q <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			seg_q <= seg_d;
			frames_q <= frames_d;
			sync_q <= sync_d;
			bit_q <= bit_d;
			half_q <= half_d;
			roll_q <= roll_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take && frame_we) begin
			frame_q <= frame_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pin_q <= pin;
			busy_q <= (phase_d != PH_IDLE);
			acc_q <= acc;
			save_q <= save;
			roll_out_q <= roll_d;
		end
	end

	assign out_valid = out_valid_q;
	assign pin_level = pin_q;
	assign busy_res = busy_q;
	assign accepted = acc_q;
	assign save_code = save_q;
	assign code_value = roll_out_q;

endmodule

[dv/rts_tx_checker.sv]
module rts_tx_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  op,
	input  logic [3:0]  button,
	input  logic [7:0]  repeat_count,
	input  logic [15:0] stored_code,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        pin_level,
	input  logic        busy_res,
	input  logic        accepted,
	input  logic [15:0] code_value,
	input  logic        save_code,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import rtsrc_pkg::*;

	localparam logic [7:0] KEY_BYTE = 8'hA0;
	localparam logic [15:0] CODE_FLOOR = 16'd1;
	localparam logic [2:0] FIRST_SYNCS = 3'd2;
	localparam logic [2:0] LATER_SYNCS = 3'd7;
	localparam logic [5:0] FRAME_LEN = 6'd56;

	typedef struct packed {
		logic        pin;
		logic        busy;
		logic        acc;
		logic [15:0] code;
		logic        save;
	} tx_result_t;

	tx_result_t expected_q[$];

	logic [23:0] address_r;
	logic [19:0] wake_len, silence_len, hw_len, sw_len, half_len, gap_len;
	logic [15:0] code_r;
	logic [7:0] frame_r [7];
	phase_t phase_r;
	logic [19:0] ticks_left;
	logic [8:0] frames_left;
	logic [2:0] syncs_left;
	logic [5:0] bit_pos;
	logic late_half;

	function automatic logic [19:0] at_least_one(input logic [19:0] v);
		return (v == '0) ? 20'd1 : v;
	endfunction

	task automatic begin_segment(input phase_t p, input logic [19:0] len);
		phase_r = p;
		ticks_left = at_least_one(len);
	endtask

	function automatic logic line_level();
		logic b;
		case (phase_r)
			PH_WAKE, PH_HW_HIGH, PH_SW_SYNC: return 1'b1;
			PH_DATA: begin
				b = frame_r[bit_pos[5:3]][3'd7 - bit_pos[2:0]];
				return late_half ? b : ~b;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic end_segment();
		case (phase_r)
			PH_WAKE: begin_segment(PH_SILENCE, silence_len);
			PH_SILENCE: begin
				syncs_left = FIRST_SYNCS;
				begin_segment(PH_HW_HIGH, hw_len);
			end
			PH_HW_HIGH: begin_segment(PH_HW_LOW, hw_len);
			PH_HW_LOW: begin
				syncs_left = syncs_left - 3'd1;
				if (syncs_left != '0) begin_segment(PH_HW_HIGH, hw_len);
				else begin_segment(PH_SW_SYNC, sw_len);
			end
			PH_SW_SYNC: begin_segment(PH_POST_SYNC, half_len);
			PH_POST_SYNC: begin
				bit_pos = '0;
				late_half = 1'b0;
				begin_segment(PH_DATA, half_len);
			end
			PH_DATA: begin
				if (!late_half) begin
					late_half = 1'b1;
					begin_segment(PH_DATA, half_len);
				end else begin
					late_half = 1'b0;
					bit_pos = bit_pos + 6'd1;
					if (bit_pos >= FRAME_LEN) begin_segment(PH_GAP, gap_len);
					else begin_segment(PH_DATA, half_len);
				end
			end
			PH_GAP: begin
				if (frames_left != '0) begin
					frames_left = frames_left - 9'd1;
					syncs_left = LATER_SYNCS;
					begin_segment(PH_HW_HIGH, hw_len);
				end else begin
					phase_r = PH_IDLE;
					ticks_left = '0;
				end
			end
			default: begin
				phase_r = PH_IDLE;
				ticks_left = '0;
			end
		endcase
	endtask

	// chained xor over key, button/checksum, code and address
	task automatic assemble_frame(input logic [3:0] btn);
		logic [3:0] sum;
		frame_r[0] = KEY_BYTE;
		frame_r[1] = {btn, 4'h0};
		frame_r[2] = code_r[15:8];
		frame_r[3] = code_r[7:0];
		frame_r[4] = address_r[23:16];
		frame_r[5] = address_r[15:8];
		frame_r[6] = address_r[7:0];
		sum = '0;
		for (int i = 0; i < 7; i++) sum = sum ^ frame_r[i][7:4] ^ frame_r[i][3:0];
		frame_r[1][3:0] = sum;
		for (int i = 1; i < 7; i++) frame_r[i] = frame_r[i] ^ frame_r[i-1];
	endtask

	task automatic step_model(
		input logic [1:0] op_in,
		input logic [3:0] btn,
		input logic [7:0] rep,
		input logic [15:0] stored,
		output tx_result_t r
	);
		logic was_busy;
		was_busy = (phase_r != PH_IDLE);
		r = '0;
		case (op_t'(op_in))
			OP_TICK: begin
				if (was_busy) begin
					r.pin = line_level();
					ticks_left = ticks_left - 20'd1;
					if (ticks_left == '0) end_segment();
				end
			end
			OP_SEND: begin
				if (!was_busy) begin
					assemble_frame(btn);
					code_r = code_r + 16'd1;
					frames_left = {1'b0, rep};
					syncs_left = '0;
					bit_pos = '0;
					late_half = 1'b0;
					begin_segment(PH_WAKE, wake_len);
					r.acc = 1'b1;
					r.save = 1'b1;
				end
				r.pin = (phase_r != PH_IDLE) ? line_level() : 1'b0;
			end
			OP_RESTORE: begin
				if (!was_busy) begin
					if (stored < CODE_FLOOR) begin
						code_r = CODE_FLOOR;
						r.save = 1'b1;
					end else begin
						code_r = stored;
					end
					r.acc = 1'b1;
				end
				r.pin = (phase_r != PH_IDLE) ? line_level() : 1'b0;
			end
			default: r.pin = was_busy ? line_level() : 1'b0;
		endcase
		r.busy = (phase_r != PH_IDLE);
		r.code = code_r;
	endtask

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10) $display("%s", msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		tx_result_t want, got;
		if (!arst_n) begin
			expected_q.delete();
			fail_count = 0;
			address_r = '0;
			wake_len = WAKEUP_RESET;
			silence_len = SILENCE_RESET;
			hw_len = HW_SYNC_RESET;
			sw_len = SW_SYNC_RESET;
			half_len = HALF_BIT_RESET;
			gap_len = GAP_RESET;
			code_r = '0;
			for (int i = 0; i < 7; i++) frame_r[i] = '0;
			phase_r = PH_IDLE;
			ticks_left = '0;
			frames_left = '0;
			syncs_left = '0;
			bit_pos = '0;
			late_half = 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_REMOTE_ADDRESS: address_r = cfg_data;
					REG_WAKEUP_TICKS: wake_len = cfg_data[19:0];
					REG_SILENCE_TICKS: silence_len = cfg_data[19:0];
					REG_HW_SYNC_TICKS: hw_len = cfg_data[19:0];
					REG_SW_SYNC_TICKS: sw_len = cfg_data[19:0];
					REG_HALF_BIT_TICKS: half_len = cfg_data[19:0];
					REG_GAP_TICKS: gap_len = cfg_data[19:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got = {pin_level, busy_res, accepted, code_value, save_code};
				if (expected_q.size() == 0) begin
					note_failure($sformatf("unexpected item: pin %b busy %b acc %b code %h save %b",
						got.pin, got.busy, got.acc, got.code, got.save));
				end else begin
					want = expected_q.pop_front();
					if (got !== want)
						note_failure($sformatf({"mismatch: expected pin %b busy %b acc %b code %h",
							" save %b, got pin %b busy %b acc %b code %h save %b"},
							want.pin, want.busy, want.acc, want.code, want.save,
							got.pin, got.busy, got.acc, got.code, got.save));
				end
			end
			if (in_valid && in_ready) begin
				step_model(op, button, repeat_count, stored_code, want);
				expected_q.push_back(want);
			end
		end
		pending = expected_q.size();
	end

endmodule

[dv/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rtsrc_pkg::*;

	localparam int MAX_TICKS = 1048575;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [3:0]  button;
	logic [7:0]  repeat_count;
	logic [15:0] stored_code;
	logic        out_valid;
	logic        out_ready;
	logic        pin_level;
	logic        busy_res;
	logic        accepted;
	logic [15:0] code_value;
	logic        save_code;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;
	int          fail_count;
	int          pending;

	bit steady;
	int wake_t, sil_t, hw_t, sw_t, half_t, gap_t;
	int count;

	rts_rolling_code_frame_transmitter DUT (.*);

	rts_tx_checker checker_i (.*);

	always #1 clk = ~clk;

	always @(negedge clk) out_ready <= steady || ($urandom_range(0, 99) >= 25);

	function automatic bit take_break();
		return !steady && ($urandom_range(0, 99) < 25);
	endfunction

	function automatic int nz(input int v);
		return (v == 0) ? 1 : v;
	endfunction

	// ticks from an accepted send until the line is idle again
	function automatic int seq_ticks(input int rep);
		return nz(wake_t) + nz(sil_t)
			+ (rep + 1) * (nz(sw_t) + 113 * nz(half_t) + nz(gap_t))
			+ (2 + 7 * rep) * 2 * nz(hw_t);
	endfunction

	task automatic push_item(input op_t o, input logic [3:0] b, input logic [7:0] r,
		input logic [15:0] s);
		@(negedge clk);
		while (take_break()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		button <= b;
		repeat_count <= r;
		stored_code <= s;
		do @(posedge clk); while (!in_ready);
		count++;
	endtask

	task automatic run_ticks(input int n);
		op_t junk;
		for (int i = 0; i < n; i++) begin
			// a stray send, restore or nop; send and restore are refused while the line is busy
			if ($urandom_range(0, 19) == 0) begin
				junk = op_t'($urandom_range(1, 3));
				push_item(junk, 4'($urandom), 8'($urandom), 16'($urandom));
			end
			push_item(OP_TICK, 4'($urandom), 8'($urandom), 16'($urandom));
		end
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [23:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_regs(input logic [23:0] addr, input int w, input int s,
		input int h, input int sw, input int hb, input int g);
		write_reg(REG_REMOTE_ADDRESS, addr);
		write_reg(REG_WAKEUP_TICKS, {4'($urandom), 20'(w)});
		write_reg(REG_SILENCE_TICKS, {4'($urandom), 20'(s)});
		write_reg(REG_HW_SYNC_TICKS, {4'($urandom), 20'(h)});
		write_reg(REG_SW_SYNC_TICKS, {4'($urandom), 20'(sw)});
		write_reg(REG_HALF_BIT_TICKS, {4'($urandom), 20'(hb)});
		write_reg(REG_GAP_TICKS, {4'($urandom), 20'(g)});
		@(negedge clk);
		cfg_valid <= 1'b0;
		wake_t = w;
		sil_t = s;
		hw_t = h;
		sw_t = sw;
		half_t = hb;
		gap_t = g;
	endtask

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int pick, rep, n;
		logic [15:0] s;
		op_t sel;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_TICK;
		button = '0;
		repeat_count = '0;
		stored_code = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_REMOTE_ADDRESS;
		cfg_data = '0;
		steady = 1'b0;
		count = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// idle line under the reset timing
		push_item(OP_TICK, 4'hF, 8'hFF, 16'hFFFF);
		push_item(OP_NOP, 4'h0, 8'h00, 16'h0000);
		push_item(OP_RESTORE, 4'h0, 8'h00, 16'h0000);
		push_item(OP_RESTORE, 4'hF, 8'hFF, 16'h0001);
		settle();

		// code wrap, refused items while busy, zero gap register
		program_regs(24'hFFFFFF, 1, 1, 1, 1, 1, 0);
		push_item(OP_RESTORE, 4'h0, 8'h00, 16'hFFFF);
		push_item(OP_SEND, 4'hF, 8'h00, 16'h0000);
		push_item(OP_SEND, 4'h3, 8'h10, 16'h1234);
		push_item(OP_RESTORE, 4'h0, 8'h00, 16'h0000);
		push_item(OP_NOP, 4'h0, 8'h00, 16'h0000);
		run_ticks(seq_ticks(0));
		push_item(OP_TICK, 4'h0, 8'h00, 16'h0000);
		push_item(OP_SEND, 4'h0, 8'h01, 16'hAAAA);
		run_ticks(seq_ticks(1));
		settle();

		// every register zero
		program_regs(24'h000000, 0, 0, 0, 0, 0, 0);
		push_item(OP_SEND, 4'h5, 8'h01, 16'h5555);
		run_ticks(seq_ticks(1));
		settle();

		// largest register values, no transmission
		program_regs(24'hFFFFFF, MAX_TICKS, MAX_TICKS, MAX_TICKS, MAX_TICKS, MAX_TICKS,
			MAX_TICKS);
		write_reg(REG_UNUSED, 24'hFFFFFF);
		@(negedge clk);
		cfg_valid <= 1'b0;
		push_item(OP_RESTORE, 4'hA, 8'h55, 16'h8000);
		push_item(OP_NOP, 4'h5, 8'hAA, 16'h7FFF);
		push_item(OP_TICK, 4'hF, 8'hFF, 16'hFFFF);

		for (int p = 0; p < 4; p++) begin
			settle();
			program_regs(24'($urandom), $urandom_range(0, 20), $urandom_range(0, 20),
				$urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 2),
				$urandom_range(0, 8));
			steady = (p == 2);
			while (count < 700 + (p + 1) * 125) begin
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					rep = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 6) : $urandom_range(0, 2);
					push_item(OP_SEND, 4'($urandom), 8'(rep), 16'($urandom));
					n = seq_ticks(rep);
					run_ticks(n);
				end else if (pick < 80) begin
					case ($urandom_range(0, 3))
						0: s = 16'h0000;
						1: s = 16'hFFFF;
						2: s = 16'h0001;
						default: s = 16'($urandom);
					endcase
					push_item(OP_RESTORE, 4'($urandom), 8'($urandom), s);
				end else begin
					sel = ($urandom_range(0, 1) == 1) ? OP_NOP : OP_TICK;
					push_item(sel, 4'($urandom), 8'($urandom), 16'($urandom));
				end
			end
		end
		steady = 1'b0;
		settle();

		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
